>>> design/coupon_collector_trial_defines.svh
// Assertion macros used by the checker file.
`ifndef COUPON_COLLECTOR_TRIAL_DEFINES_SVH
`define COUPON_COLLECTOR_TRIAL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ccol_pkg.sv
package ccol_pkg;

    // Trial limits
    localparam int unsigned MAX_DRAWS   = 1048576;
    localparam int unsigned MAX_KINDS   = 64;
    localparam int unsigned DRAW_W      = $clog2(MAX_DRAWS + 1);
    localparam int unsigned N_W         = $clog2(MAX_KINDS + 1);
    localparam int unsigned KIND_W      = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
    localparam int unsigned NUM_KINDS_W = 7;
    localparam logic [NUM_KINDS_W-1:0] NUM_KINDS_RST = NUM_KINDS_W'(10);

    // Hash arithmetic
    localparam int unsigned X_W      = 31;
    localparam int unsigned B_W      = 32;
    localparam int unsigned PROD_W   = X_W + B_W;
    localparam int unsigned FOLD_W   = 33;
    localparam int unsigned SEED_W   = 40;
    localparam logic [X_W-1:0] MOD_M    = 31'h7FFF_FFFF;
    localparam logic [B_W-1:0] MUL_SEED = 32'd2654435761;
    localparam logic [B_W-1:0] MUL_R1   = 32'd1812433253;
    localparam logic [B_W-1:0] MUL_R2   = 32'd1664525;
    localparam int unsigned SHIFT_A  = 16;
    localparam int unsigned SHIFT_B  = 13;
    localparam int unsigned HASH_ROUNDS = 3;
    localparam int unsigned ROUND_W  = $clog2(HASH_ROUNDS);

    // Reciprocal floor(2^31 / n), one quotient bit per cycle
    localparam int unsigned DIV_STEPS = B_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RECIP,
        ST_MUL,
        ST_FOLD1,
        ST_FOLD2,
        ST_MIX,
        ST_MULQ,
        ST_MULN,
        ST_REM,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MS_SEED,
        MS_R1,
        MS_R2,
        MS_QUOT,
        MS_NMUL
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  div_step;
        logic  div_first;
        logic  mul_en;
        t_msel msel;
        logic  fold1_en;
        logic  add_k;
        logic  fold2_en;
        logic  mix_en;
        logic  rem_en;
    } t_ctl;

    // Mask with the low n bits set
    function automatic logic [MAX_KINDS-1:0] full_mask(input logic [N_W-1:0] n);
        logic [MAX_KINDS:0] ext;
        ext = ((MAX_KINDS+1)'(1) << n) - (MAX_KINDS+1)'(1);
        return ext[MAX_KINDS-1:0];
    endfunction

endpackage

>>> design/coupon_collector_trial.sv
// Channel   Valid         Stall         Payload
// -------   -----------   -----------   ------------------------------
// input     i_in_valid    o_in_stall    i_trial_seed[39:0]
// output    o_out_valid   i_out_stall   o_draw_count[20:0], o_capped
// config    i_cfg_we      (none)        i_cfg_wdata[6:0]  (num_kinds)
//
// A trial makes about N*H_N draws. It first builds floor(2^31/n) one
// quotient bit per cycle; each draw then makes five passes through the one
// 31x32 multiplier (three hash rounds, quotient, quotient times n) plus the
// mod (2^31-1) folds.
// Reset is synchronous, active low; num_kinds returns to 10, the output empties.
// The output register lets a new trial start while a result waits; a finished
// trial holds in its done state only while that register is full and stalled.
module coupon_collector_trial
    import ccol_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // trial input
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SEED_W-1:0]      i_trial_seed,
    // result output
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [DRAW_W-1:0]      o_draw_count,
    output logic                   o_capped,
    // num_kinds register
    input  logic                   i_cfg_we,
    input  logic [NUM_KINDS_W-1:0] i_cfg_wdata
);

    logic [NUM_KINDS_W-1:0] r_num_kinds;
    logic                   r_out_valid;
    logic [DRAW_W-1:0]      r_draw_count;
    logic                   r_capped;

    t_ctl                   ctl;
    logic                   in_ready;
    logic                   publish;
    logic                   out_free;
    logic                   trial_done;
    logic [DRAW_W-1:0]      dp_count;
    logic                   dp_capped;

    // Output slot frees up when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    ccol_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_out_free   (out_free),
        .i_trial_done (trial_done),
        .o_ctl        (ctl),
        .o_in_ready   (in_ready),
        .o_publish    (publish)
    );

    ccol_dp u_dp (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_trial_seed (i_trial_seed),
        .i_num_kinds  (r_num_kinds),
        .o_trial_done (trial_done),
        .o_draw_count (dp_count),
        .o_capped     (dp_capped)
    );

    // num_kinds register; clamping to 1..MAX_KINDS happens per trial
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_kinds <= NUM_KINDS_RST;
        end else if (i_cfg_we) begin
            r_num_kinds <= i_cfg_wdata;
        end
    end

    // Output register: one result transaction per trial
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            r_draw_count <= dp_count;
            r_capped     <= dp_capped;
        end
    end

    assign o_in_stall   = !in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_draw_count = r_draw_count;
    assign o_capped     = r_capped;

endmodule

>>> design/ccol_mul.sv
module ccol_mul
    import ccol_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [X_W-1:0]    i_a,
    input  logic [B_W-1:0]    i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> design/ccol_dp.sv
module ccol_dp
    import ccol_pkg::*;
(
    input  logic                   i_clk,
    input  t_ctl                   i_ctl,
    input  logic [SEED_W-1:0]      i_trial_seed,
    input  logic [NUM_KINDS_W-1:0] i_num_kinds,
    output logic                   o_trial_done,
    output logic [DRAW_W-1:0]      o_draw_count,
    output logic                   o_capped
);

    logic [X_W-1:0]       r_sm;
    logic [X_W-1:0]       r_x;
    logic [FOLD_W-1:0]    r_fold;
    logic [N_W-1:0]       r_n;
    logic [KIND_W-1:0]    r_rem;
    logic [B_W-1:0]       r_recip;
    logic [MAX_KINDS-1:0] r_mask;
    logic [MAX_KINDS-1:0] r_full;
    logic [DRAW_W-1:0]    r_k;
    logic [DRAW_W-1:0]    r_count;
    logic                 r_capped;

    logic [PROD_W-1:0]    prod;
    logic [X_W-1:0]       mul_a;
    logic [B_W-1:0]       mul_b;
    logic [B_W-1:0]       seed_fold;
    logic [X_W-1:0]       seed_mod;
    logic [N_W-1:0]       n_eff;
    logic [N_W-1:0]       div_t;
    logic                 div_ge;
    logic [FOLD_W-1:0]    addend;
    logic [B_W-1:0]       fold2_sum;
    logic [X_W-1:0]       mix_y;
    logic [X_W-1:0]       diff;
    logic [N_W:0]         rlo;
    logic [N_W:0]         kind_raw;
    logic [KIND_W-1:0]    kind;
    logic [MAX_KINDS-1:0] mask_new;
    logic [DRAW_W-1:0]    k_new;

    // Seed mod (2^31-1) by folding the top bits back in
    always_comb begin
        seed_fold = B_W'(i_trial_seed[X_W-1:0]) + B_W'(i_trial_seed[SEED_W-1:X_W]);
        seed_mod  = (seed_fold >= B_W'(MOD_M)) ? X_W'(seed_fold - B_W'(MOD_M))
                                                 : seed_fold[X_W-1:0];
        if (i_num_kinds == '0) begin
            n_eff = N_W'(1);
        end else if (NUM_KINDS_W'(i_num_kinds) > NUM_KINDS_W'(MAX_KINDS)) begin
            n_eff = N_W'(MAX_KINDS);
        end else begin
            n_eff = N_W'(i_num_kinds);
        end
    end

    // Restoring division step; dividend is 2^31, so only the first bit is set
    always_comb begin
        div_t  = {r_rem, i_ctl.div_first};
        div_ge = (div_t >= r_n);
    end

    // Operand select for the shared multiplier
    always_comb begin
        case (i_ctl.msel)
            MS_SEED: begin
                mul_a = r_sm;
                mul_b = MUL_SEED;
            end
            MS_R1: begin
                mul_a = r_x ^ (r_x >> SHIFT_A);
                mul_b = MUL_R1;
            end
            MS_R2: begin
                mul_a = r_x ^ (r_x >> SHIFT_B);
                mul_b = MUL_R2;
            end
            MS_QUOT: begin
                mul_a = r_x;
                mul_b = r_recip;
            end
            MS_NMUL: begin
                mul_a = prod[2*X_W-1:X_W];
                mul_b = B_W'(r_n);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ccol_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (i_ctl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        addend    = i_ctl.add_k ? (FOLD_W'(r_k) + FOLD_W'(1)) : '0;
        fold2_sum = B_W'(r_fold[X_W-1:0]) + B_W'(r_fold[FOLD_W-1:X_W]);
        mix_y     = r_x ^ (r_x >> SHIFT_A);
        // quotient estimate is low by at most one, so remainder < 2n
        diff      = r_x - prod[X_W-1:0];
        rlo       = diff[N_W:0];
        kind_raw  = (rlo >= (N_W+1)'(r_n)) ? (rlo - (N_W+1)'(r_n)) : rlo;
        kind      = kind_raw[KIND_W-1:0];
        mask_new  = r_mask | (MAX_KINDS'(1) << kind);
        k_new     = r_k + DRAW_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sm    <= seed_mod;
            r_n     <= n_eff;
            r_full  <= full_mask(n_eff);
            r_mask  <= '0;
            r_k     <= '0;
            r_rem   <= '0;
        end
        if (i_ctl.div_step) begin
            r_rem   <= div_ge ? KIND_W'(div_t - r_n) : div_t[KIND_W-1:0];
            r_recip <= {r_recip[B_W-2:0], div_ge};
        end
        if (i_ctl.fold1_en) begin
            r_fold <= FOLD_W'(prod[X_W-1:0]) + FOLD_W'(prod[PROD_W-1:X_W]) + addend;
        end
        if (i_ctl.fold2_en) begin
            r_x <= (fold2_sum >= B_W'(MOD_M)) ? X_W'(fold2_sum - B_W'(MOD_M))
                                                : fold2_sum[X_W-1:0];
        end
        if (i_ctl.mix_en) begin
            r_x <= (mix_y == MOD_M) ? '0 : mix_y;
        end
        if (i_ctl.rem_en) begin
            r_mask   <= mask_new;
            r_k      <= k_new;
            r_count  <= k_new;
            r_capped <= (mask_new != r_full);
        end
    end

    assign o_trial_done = i_ctl.rem_en &&
                          ((mask_new == r_full) || (k_new == DRAW_W'(MAX_DRAWS)));
    assign o_draw_count = r_count;
    assign o_capped     = r_capped;

endmodule

>>> design/ccol_ctrl.sv
module ccol_ctrl
    import ccol_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_free,
    input  logic i_trial_done,
    output t_ctl o_ctl,
    output logic o_in_ready,
    output logic o_publish
);

    t_state               r_state, n_state;
    logic [ROUND_W-1:0]   r_round, n_round;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_round   <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_div_cnt <= n_div_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_div_cnt = r_div_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state   = ST_RECIP;
                    n_div_cnt = '0;
                end
            end
            ST_RECIP: begin
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MUL;
                    n_round = '0;
                end
            end
            ST_MUL:   n_state = ST_FOLD1;
            ST_FOLD1: n_state = ST_FOLD2;
            ST_FOLD2: begin
                if (r_round == ROUND_W'(HASH_ROUNDS - 1)) begin
                    n_state = ST_MIX;
                end else begin
                    n_state = ST_MUL;
                    n_round = r_round + ROUND_W'(1);
                end
            end
            ST_MIX:  n_state = ST_MULQ;
            ST_MULQ: n_state = ST_MULN;
            ST_MULN: n_state = ST_REM;
            ST_REM: begin
                if (i_trial_done) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                    n_round = '0;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        o_publish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            ST_RECIP: begin
                o_ctl.div_step  = 1'b1;
                o_ctl.div_first = (r_div_cnt == '0);
            end
            ST_MUL: begin
                o_ctl.mul_en = 1'b1;
                if (r_round == '0) begin
                    o_ctl.msel = MS_SEED;
                end else if (r_round == ROUND_W'(1)) begin
                    o_ctl.msel = MS_R1;
                end else begin
                    o_ctl.msel = MS_R2;
                end
            end
            ST_FOLD1: begin
                o_ctl.fold1_en = 1'b1;
                o_ctl.add_k    = (r_round == '0);
            end
            ST_FOLD2: o_ctl.fold2_en = 1'b1;
            ST_MIX:   o_ctl.mix_en   = 1'b1;
            ST_MULQ: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.msel   = MS_QUOT;
            end
            ST_MULN: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.msel   = MS_NMUL;
            end
            ST_REM:  o_ctl.rem_en = 1'b1;
            ST_DONE: o_publish    = i_out_free;
            default: o_ctl = '0;
        endcase
    end

endmodule

>>> design/ccol_chk.sv
`include "coupon_collector_trial_defines.svh"

module ccol_chk
    import ccol_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DRAW_W-1:0] o_draw_count,
    input logic              o_capped
);

    logic              in_take;
    logic              out_held;
    logic              cap_out;
    logic [DRAW_W+1:0] out_word;
    logic              count_full;
    logic              count_ok;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_held   = o_out_valid && i_out_stall;
    assign cap_out    = o_out_valid && o_capped;
    assign out_word   = {o_out_valid, o_draw_count, o_capped};
    assign count_full = (o_draw_count == DRAW_W'(MAX_DRAWS));
    assign count_ok   = (o_draw_count != '0) && (o_draw_count <= DRAW_W'(MAX_DRAWS));

    // a capped trial always reports the full draw budget
    `CCT_ASSERT_IMPL(a_cap_count, i_clk, i_rst_n, cap_out, count_full, "bad capped count")

    // every trial draws at least once and never beyond the cap
    `CCT_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, o_out_valid, count_ok, "draw count out of range")

    // a trial occupies the block for the cycle after it is taken
    `CCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall, "input taken twice")

    // stalled result holds
    `CCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, $stable(out_word), "stalled result changed")

endmodule

bind coupon_collector_trial ccol_chk u_ccol_chk (.*);
